// File: hdl/gld_pkg.sv
// Shared types and constants of the GIF LZW decoder.
package gld_pkg;

  // Input actions.
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_PULL = 1'b1;

  // Result status codes.
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_REFUSE = 2'd1;
  localparam logic [1:0] STAT_END    = 2'd2;
  localparam logic [1:0] STAT_ERR    = 2'd3;

  // Literal width limits and reset value of the register.
  localparam logic [3:0] LIT_MIN   = 4'd2;
  localparam logic [3:0] LIT_MAX   = 4'd8;
  localparam logic [3:0] MCS_RESET = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PEND,
    ST_WALK_H,
    ST_WALK_C,
    ST_FINISH
  } gld_state_e;

  function automatic logic [3:0] lit_bits(input logic [3:0] mcs);
    logic [3:0] r;
    r = mcs;
    if (mcs < LIT_MIN) r = LIT_MIN;
    if (mcs > LIT_MAX) r = LIT_MAX;
    return r;
  endfunction

endpackage

// File: hdl/gld_ifs.sv
// Valid/ready channel interfaces of the GIF LZW decoder.
interface gld_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] code_byte;

  modport source (output valid, action, code_byte, input ready);
  modport sink   (input valid, action, code_byte, output ready);
endinterface

interface gld_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic [1:0] status;

  modport source (output valid, out_byte, out_valid, status, input ready);
  modport sink   (input valid, out_byte, out_valid, status, output ready);
endinterface

// File: hdl/gif_lzw_decoder_core.sv
// Top level of the GIF LZW decoder: bit buffer, dictionary walk and byte stack.
//
// Every beat on in_i produces exactly one beat on out_o. A push (action 0)
// appends code_byte to the bit buffer and answers in the next cycle; it is
// refused with status 1 while a complete code already waits. A pull
// (action 1) returns the next byte of the current expansion, read from the
// expansion memory in the pending state. When nothing is pending it
// decodes the next code: the dictionary walk reads one entry per cycle (a
// string that repeats the previous one walks its chain twice). The first
// byte comes with that result, later bytes come from later pulls. End and
// error are sticky.
// Both dictionary and expansion memories hold 2**MAX_CODE_WIDTH entries and
// are never cleared; reset only restores the control registers.
// The result register holds a beat until out_o is ready; a new beat is
// taken only when that register is free or drains in the same cycle.
// cfg_we_i loads min_code_size and restarts the dictionary; write it only
// while the block is idle.
module gif_lzw_decoder_core #(
  parameter int MAX_CODE_WIDTH = 12
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  gld_in_if.sink       in_i,
  gld_out_if.source    out_o,
  input  logic         cfg_we_i,
  input  logic [3:0]   cfg_data_i
);

  localparam int MCW   = MAX_CODE_WIDTH;
  localparam int TSIZE = 1 << MCW;
  localparam int BBW   = MCW + 8;
  localparam int BCW   = $clog2(BBW + 1);

  localparam logic [MCW-1:0] TOP_IDX  = MCW'(TSIZE - 1);
  localparam logic [MCW-1:0] TOP2_IDX = MCW'(TSIZE - 2);

  gld_pkg::gld_state_e state_q, state_d;

  logic [3:0]     mcs_q, mcs_d;
  logic [3:0]     cw_q, cw_d;
  logic [MCW:0]   hi_q, hi_d;
  logic [MCW-1:0] prev_q, prev_d;
  logic           prev_ok_q, prev_ok_d;
  logic [BBW-1:0] bb_q, bb_d;
  logic [BCW-1:0] bc_q, bc_d;
  logic [MCW:0]   pend_q, pend_d;
  logic [1:0]     final_q, final_d;
  logic [MCW-1:0] h_q, h_d;
  logic [MCW:0]   n_q, n_d;
  logic [MCW-1:0] c_q, c_d;
  logic [MCW-1:0] i_q, i_d;
  logic [MCW-1:0] code_q, code_d;

  logic           ovld_q, ovld_d;
  logic [7:0]     ob_q, ob_d;
  logic           ov_q, ov_d;
  logic [1:0]     st_q, st_d;

  // Dictionary entry: prefix code in the upper bits, suffix byte below.
  logic [MCW+7:0] dict_mem [TSIZE];
  logic [MCW+7:0] dict_rd_q;
  logic [MCW-1:0] dict_raddr;
  logic           dict_we;
  logic [MCW+7:0] dict_wdata;
  logic [MCW-1:0] rd_prefix;
  logic [7:0]     rd_suffix;

  logic [7:0]     exp_mem [TSIZE];
  logic [7:0]     exp_rd_q;
  logic           exp_we;
  logic [MCW-1:0] exp_waddr;
  logic [7:0]     exp_wdata;

  logic           accept, is_pull, have_pend, finished, code_rdy, produce;
  logic [3:0]     lit;
  logic [MCW-1:0] clear_w, mask_w, code_w;
  logic           dec, dec_clear, dec_end, dec_err, dec_lit, dec_kwk;
  logic           h_lit, c_next_lit, n_full;
  logic [MCW:0]   hi_inc, limit_w;

  assign lit        = gld_pkg::lit_bits(mcs_q);
  assign clear_w    = MCW'(1) << lit;
  assign mask_w     = ~({MCW{1'b1}} << cw_q);
  assign code_w     = bb_q[MCW-1:0] & mask_w;
  assign rd_prefix  = dict_rd_q[MCW+7:8];
  assign rd_suffix  = dict_rd_q[7:0];

  assign in_i.ready = (state_q == gld_pkg::ST_IDLE) && (!ovld_q || out_o.ready);
  assign accept     = in_i.valid && in_i.ready;
  assign is_pull    = (in_i.action == gld_pkg::ACT_PULL);
  assign have_pend  = !pend_q[MCW];
  assign finished   = (final_q != gld_pkg::STAT_OK);
  assign code_rdy   = ({1'b0, bc_q} >= (BCW + 1)'(cw_q));

  assign dec        = accept && is_pull && !have_pend && !finished && code_rdy;
  assign dec_clear  = (code_w == clear_w);
  assign dec_end    = (code_w == clear_w + MCW'(1));
  assign dec_err    = ({1'b0, code_w} > hi_q) || hi_q[MCW];
  assign dec_lit    = (code_w < clear_w);
  assign dec_kwk    = ({1'b0, code_w} == hi_q) && prev_ok_q;

  assign h_lit      = (h_q < clear_w);
  assign n_full     = n_q[MCW];
  assign c_next_lit = (rd_prefix < clear_w);
  assign hi_inc     = hi_q + (MCW + 1)'(1);
  assign limit_w    = (MCW + 1)'(1) << cw_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      gld_pkg::ST_IDLE: begin
        if (accept && is_pull && have_pend) begin
          state_d = gld_pkg::ST_PEND;
        end else if (dec && !dec_clear && !dec_end && !dec_err) begin
          if (dec_lit) state_d = gld_pkg::ST_FINISH;
          else if (dec_kwk) state_d = gld_pkg::ST_WALK_H;
          else state_d = gld_pkg::ST_WALK_C;
        end
      end
      gld_pkg::ST_PEND: state_d = gld_pkg::ST_IDLE;
      gld_pkg::ST_WALK_H: begin
        if (h_lit) begin
          state_d = (prev_q < clear_w) ? gld_pkg::ST_FINISH : gld_pkg::ST_WALK_C;
        end else if (n_full) begin
          state_d = gld_pkg::ST_IDLE;
        end
      end
      gld_pkg::ST_WALK_C: begin
        if (i_q == '0) state_d = gld_pkg::ST_IDLE;
        else if (c_next_lit) state_d = gld_pkg::ST_FINISH;
      end
      gld_pkg::ST_FINISH: state_d = gld_pkg::ST_IDLE;
      default: state_d = gld_pkg::ST_IDLE;
    endcase
  end

  // Datapath and results.
  always_comb begin
    mcs_d = mcs_q;  cw_d = cw_q;  hi_d = hi_q;  prev_d = prev_q;
    prev_ok_d = prev_ok_q;  bb_d = bb_q;  bc_d = bc_q;  pend_d = pend_q;
    final_d = final_q;  h_d = h_q;  n_d = n_q;  c_d = c_q;  i_d = i_q;
    code_d = code_q;
    produce = 1'b0;
    ob_d = 8'd0;  ov_d = 1'b0;  st_d = gld_pkg::STAT_OK;
    dict_raddr = code_w;
    dict_we = 1'b0;
    dict_wdata = {prev_q, c_q[7:0]};
    exp_we = 1'b0;
    exp_waddr = i_q;
    exp_wdata = c_q[7:0];

    case (state_q)
      gld_pkg::ST_IDLE: begin
        dict_raddr = dec_kwk ? prev_q : code_w;
        if (cfg_we_i) begin
          mcs_d     = cfg_data_i;
          cw_d      = gld_pkg::lit_bits(cfg_data_i) + 4'd1;
          hi_d      = ((MCW + 1)'(1) << gld_pkg::lit_bits(cfg_data_i)) + (MCW + 1)'(1);
          prev_ok_d = 1'b0;
        end
        if (accept && !is_pull) begin
          produce = 1'b1;
          if (finished) begin
            st_d = final_q;
          end else if (code_rdy) begin
            st_d = gld_pkg::STAT_REFUSE;
          end else begin
            bb_d = bb_q | (BBW'(in_i.code_byte) << bc_q);
            bc_d = bc_q + BCW'(8);
          end
        end else if (accept && !have_pend) begin
          if (!dec) begin
            produce = 1'b1;
            st_d = final_q;
          end else begin
            bb_d   = bb_q >> cw_q;
            bc_d   = bc_q - BCW'(cw_q);
            code_d = code_w;
            c_d    = code_w;
            i_d    = TOP_IDX;
            h_d    = prev_q;
            n_d    = '0;
            if (dec_clear) begin
              produce   = 1'b1;
              cw_d      = lit + 4'd1;
              hi_d      = {1'b0, clear_w} + (MCW + 1)'(1);
              prev_ok_d = 1'b0;
            end else if (dec_end) begin
              produce = 1'b1;
              final_d = gld_pkg::STAT_END;
              st_d    = gld_pkg::STAT_END;
            end else if (dec_err) begin
              produce = 1'b1;
              final_d = gld_pkg::STAT_ERR;
              st_d    = gld_pkg::STAT_ERR;
            end
          end
        end
      end
      gld_pkg::ST_PEND: begin
        produce = 1'b1;
        ob_d    = exp_rd_q;
        ov_d    = 1'b1;
        pend_d  = pend_q + (MCW + 1)'(1);
      end
      gld_pkg::ST_WALK_H: begin
        // Find the first byte of the previous string for the repeat case.
        if (h_lit) begin
          dict_raddr = prev_q;
          exp_we     = 1'b1;
          exp_waddr  = TOP_IDX;
          exp_wdata  = h_q[7:0];
          i_d        = TOP2_IDX;
          c_d        = prev_q;
        end else if (n_full) begin
          produce = 1'b1;
          final_d = gld_pkg::STAT_ERR;
          st_d    = gld_pkg::STAT_ERR;
        end else begin
          dict_raddr = rd_prefix;
          h_d        = rd_prefix;
          n_d        = n_q + (MCW + 1)'(1);
        end
      end
      gld_pkg::ST_WALK_C: begin
        // Stack suffix bytes from the end of the string toward its start.
        dict_raddr = rd_prefix;
        if (i_q == '0) begin
          produce = 1'b1;
          final_d = gld_pkg::STAT_ERR;
          st_d    = gld_pkg::STAT_ERR;
        end else begin
          exp_we    = 1'b1;
          exp_wdata = rd_suffix;
          i_d       = i_q - MCW'(1);
          c_d       = rd_prefix;
        end
      end
      gld_pkg::ST_FINISH: begin
        produce   = 1'b1;
        exp_we    = 1'b1;
        dict_we   = prev_ok_q;
        prev_d    = code_q;
        prev_ok_d = 1'b1;
        if (hi_inc > limit_w) begin
          final_d = gld_pkg::STAT_ERR;
          st_d    = gld_pkg::STAT_ERR;
          prev_d  = prev_q;
          prev_ok_d = prev_ok_q;
        end else begin
          ob_d   = c_q[7:0];
          ov_d   = 1'b1;
          pend_d = {1'b0, i_q} + (MCW + 1)'(1);
          hi_d   = hi_inc;
          if (hi_inc == limit_w) begin
            // At full width the dictionary freezes instead of growing.
            if (cw_q >= 4'(MCW)) begin
              prev_ok_d = 1'b0;
              hi_d      = hi_q;
            end else begin
              cw_d = cw_q + 4'd1;
            end
          end
        end
      end
      default: ;
    endcase

    ovld_d = produce ? 1'b1 : (ovld_q && !out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= gld_pkg::ST_IDLE;
      mcs_q     <= gld_pkg::MCS_RESET;
      cw_q      <= gld_pkg::lit_bits(gld_pkg::MCS_RESET) + 4'd1;
      hi_q      <= ((MCW + 1)'(1) << gld_pkg::lit_bits(gld_pkg::MCS_RESET)) + (MCW + 1)'(1);
      prev_ok_q <= 1'b0;
      bb_q      <= '0;
      bc_q      <= '0;
      pend_q    <= (MCW + 1)'(TSIZE);
      final_q   <= gld_pkg::STAT_OK;
      ovld_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      mcs_q     <= mcs_d;
      cw_q      <= cw_d;
      hi_q      <= hi_d;
      prev_ok_q <= prev_ok_d;
      bb_q      <= bb_d;
      bc_q      <= bc_d;
      pend_q    <= pend_d;
      final_q   <= final_d;
      ovld_q    <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
    h_q    <= h_d;
    n_q    <= n_d;
    c_q    <= c_d;
    i_q    <= i_d;
    code_q <= code_d;
    if (produce) begin
      ob_q <= ob_d;
      ov_q <= ov_d;
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dict_we) dict_mem[hi_q[MCW-1:0]] <= dict_wdata;
    dict_rd_q <= dict_mem[dict_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (exp_we) exp_mem[exp_waddr] <= exp_wdata;
    exp_rd_q <= exp_mem[pend_q[MCW-1:0]];
  end

  assign out_o.valid     = ovld_q;
  assign out_o.out_byte  = ob_q;
  assign out_o.out_valid = ov_q;
  assign out_o.status    = st_q;

  // A result is only written into a free or draining output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    produce |-> (!ovld_q || out_o.ready))
    else $error("result overwrote an undelivered beat");

  // The pending pointer never runs past the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= (MCW + 1)'(TSIZE))
    else $error("pending pointer out of range");

  // A beat taken in idle either answers at once or moves the block out of idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !produce) |=> (state_q != gld_pkg::ST_IDLE))
    else $error("accepted item produced no result");

  // Code width stays within the parameter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cw_q <= 4'(MCW))
    else $error("code width exceeds maximum");

endmodule

// File: sim/gld_lzw_checker.sv
// Checker for the GIF LZW decoder: tracks decoder state, predicts each result and compares.
module gld_lzw_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_data_i,
  gld_in_if          in_mon_i,
  gld_out_if         out_mon_i,
  output int         fail_count_o,
  output int         open_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DICT_SIZE = 4096;
  localparam int unsigned NO_PREV   = 32'h1FFF;

  typedef struct {
    logic [7:0] data;
    logic       data_ok;
    logic [1:0] status;
  } dec_result_t;

  logic [11:0] dict_prefix [DICT_SIZE];
  logic [7:0]  dict_suffix [DICT_SIZE];
  logic [7:0]  stack_mem   [DICT_SIZE];
  int unsigned stack_ptr;
  int unsigned bit_acc;
  int unsigned bit_num;
  int unsigned code_w;
  int unsigned next_code;
  int unsigned last_code;
  logic [1:0]  done_state;
  logic [3:0]  lit_cfg;
  dec_result_t expected_q[$];

  initial begin
    for (int k = 0; k < DICT_SIZE; k++) begin
      dict_prefix[k] = '0;
      dict_suffix[k] = '0;
      stack_mem[k]   = '0;
    end
    fail_count_o = 0;
    open_count_o = 0;
  end

  function automatic int unsigned lit_eff();
    if (lit_cfg < 4'd2) return 2;
    if (lit_cfg > 4'd8) return 8;
    return lit_cfg;
  endfunction

  function automatic void restart_dict();
    code_w    = lit_eff() + 1;
    next_code = (1 << lit_eff()) + 1;
    last_code = NO_PREV;
  endfunction

  // Returns 1 when the code left bytes on the expansion stack.
  function automatic bit decode_one(input int unsigned code);
    int unsigned clr, hi, prv, idx, c, h, n, lim;
    bit prv_ok;
    clr    = 1 << lit_eff();
    hi     = next_code;
    prv    = last_code;
    prv_ok = prv < DICT_SIZE;
    idx    = DICT_SIZE - 1;
    if (code == clr) begin
      restart_dict();
      return 0;
    end
    if (code == clr + 1) begin
      done_state = gld_pkg::STAT_END;
      return 0;
    end
    if (code > hi || hi >= DICT_SIZE) begin
      done_state = gld_pkg::STAT_ERR;
      return 0;
    end
    c = code;
    if (code >= clr) begin
      // A code one past the table repeats the previous string plus its own first byte.
      if (code == hi && prv_ok) begin
        h = prv;
        n = 0;
        while (h >= clr && n < DICT_SIZE) begin
          h = dict_prefix[h % DICT_SIZE];
          n++;
        end
        if (h >= clr) begin
          done_state = gld_pkg::STAT_ERR;
          return 0;
        end
        stack_mem[idx] = h[7:0];
        idx--;
        c = prv;
      end
      while (c >= clr) begin
        if (idx == 0) begin
          done_state = gld_pkg::STAT_ERR;
          return 0;
        end
        stack_mem[idx] = dict_suffix[c % DICT_SIZE];
        idx--;
        c = dict_prefix[c % DICT_SIZE];
      end
    end
    stack_mem[idx] = c[7:0];
    if (prv_ok) begin
      dict_suffix[hi] = c[7:0];
      dict_prefix[hi] = prv[11:0];
    end
    last_code = code;
    hi++;
    lim = 1 << code_w;
    if (hi >= lim) begin
      if (hi > lim) begin
        done_state = gld_pkg::STAT_ERR;
        return 0;
      end
      if (code_w >= 12) begin
        last_code = NO_PREV;
        hi--;
      end else begin
        code_w++;
      end
    end
    next_code = hi;
    stack_ptr = idx;
    return 1;
  endfunction

  function automatic dec_result_t predict_step(input logic act, input logic [7:0] byt);
    dec_result_t res;
    bit have;
    int unsigned code;
    res  = '{8'd0, 1'b0, gld_pkg::STAT_OK};
    have = 0;
    if (act == gld_pkg::ACT_PUSH) begin
      if (done_state != gld_pkg::STAT_OK) begin
        res.status = done_state;
      end else if (bit_num >= code_w) begin
        res.status = gld_pkg::STAT_REFUSE;
      end else begin
        bit_acc = (bit_acc | (int'(byt) << bit_num)) & 32'hFFFFF;
        bit_num = bit_num + 8;
      end
    end else begin
      if (stack_ptr < DICT_SIZE) begin
        have = 1;
      end else if (done_state != gld_pkg::STAT_OK) begin
        res.status = done_state;
      end else if (bit_num >= code_w) begin
        code    = bit_acc & ((1 << code_w) - 1);
        bit_acc = bit_acc >> code_w;
        bit_num = bit_num - code_w;
        if (decode_one(code)) have = 1;
        else res.status = done_state;
      end
      if (have) begin
        res.data    = stack_mem[stack_ptr % DICT_SIZE];
        res.data_ok = 1'b1;
        stack_ptr++;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    dec_result_t want, got;
    if (!rst_ni) begin
      stack_ptr  = DICT_SIZE;
      bit_acc    = 0;
      bit_num    = 0;
      done_state = gld_pkg::STAT_OK;
      lit_cfg    = gld_pkg::MCS_RESET;
      restart_dict();
      expected_q.delete();
      open_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        lit_cfg = cfg_data_i;
        restart_dict();
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        expected_q.push_back(predict_step(in_mon_i.action, in_mon_i.code_byte));
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        got = '{out_mon_i.out_byte, out_mon_i.out_valid, out_mon_i.status};
        if (expected_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("unexpected result beat: byte %h valid %b status %0d",
                     got.data, got.data_ok, got.status);
        end else begin
          want = expected_q.pop_front();
          if (got.data !== want.data || got.data_ok !== want.data_ok ||
              got.status !== want.status) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display({"result mismatch: expected byte %h valid %b status %0d, ",
                        "got byte %h valid %b status %0d"},
                       want.data, want.data_ok, want.status,
                       got.data, got.data_ok, got.status);
          end
        end
      end
      open_count_o = expected_q.size();
    end
  end

endmodule

// File: sim/tb_gif_lzw_decoder_core.sv
// Testbench top of the GIF LZW decoder: clock, reset, code-stream stimulus and verdict.
module tb_gif_lzw_decoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 1050;
  localparam int IDLE_LIMIT  = 20000;

  typedef struct {
    bit         is_cfg;
    logic [3:0] cfg;
    int         code;
    int         width;
    int         len;
  } lzw_code_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [3:0] cfg_data;
  int         fail_count;
  int         open_count;

  gld_in_if  in_ch ();
  gld_out_if out_ch ();

  gif_lzw_decoder_core dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_i      (in_ch),
    .out_o     (out_ch),
    .cfg_we_i  (cfg_we),
    .cfg_data_i(cfg_data)
  );

  gld_lzw_checker checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data),
    .in_mon_i    (in_ch),
    .out_mon_i   (out_ch),
    .fail_count_o(fail_count),
    .open_count_o(open_count)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stream generator state: mirrors the decoder's table growth so that codes stay legal.
  int         g_lit, g_clear, g_hi, g_width, g_prev, g_cap, g_phase_left;
  bit         g_prev_ok;
  bit         g_stop;
  int         g_len [4096];
  int         cfg_idx;
  logic [3:0] cfg_plan [4] = '{gld_pkg::LIT_MIN, 4'd15, 4'd0, gld_pkg::LIT_MAX};
  lzw_code_t  codeq[$];
  bit         bitq[$];
  int         have_bits;
  bit         force_odd;
  int         sent;
  int         s_burst;
  int         r_burst, hold_left, idle_cycles;
  bit         held;

  function automatic void gen_restart();
    g_clear   = 1 << g_lit;
    g_hi      = g_clear + 1;
    g_width   = g_lit + 1;
    g_prev_ok = 0;
    for (int c = 0; c < g_clear; c++) g_len[c] = 1;
  endfunction

  function automatic void gen_emit(input int code);
    int n;
    if (code == g_clear) n = 0;
    else if (code == g_clear + 1 || code > g_hi) n = 0;
    else if (code < g_clear) n = 1;
    else if (code == g_hi) n = g_len[g_prev] + 1;
    else n = g_len[code];
    codeq.push_back('{1'b0, 4'd0, code, g_width, n});
    for (int k = 0; k < g_width; k++) bitq.push_back(bit'((code >> k) & 1));
    if (code == g_clear) begin
      gen_restart();
      return;
    end
    if (code == g_clear + 1 || code > g_hi) return;
    if (g_prev_ok) g_len[g_hi] = g_len[g_prev] + 1;
    g_prev    = code;
    g_prev_ok = 1;
    g_hi++;
    if (g_hi >= (1 << g_width) && g_width < 12) g_width++;
  endfunction

  function automatic void gen_random();
    int r;
    logic [3:0] v;
    if (g_phase_left <= 0) begin
      if (cfg_idx < 4) v = cfg_plan[cfg_idx];
      else v = 4'($urandom_range(0, 15));
      cfg_idx++;
      codeq.push_back('{1'b1, v, 0, 0, 0});
      g_lit = (v < 2) ? 2 : (v > 8) ? 8 : int'(v);
      gen_restart();
      g_cap = g_clear + 2 + (($urandom_range(0, 3) == 0) ? $urandom_range(300, 1000)
                                                         : $urandom_range(10, 150));
      g_phase_left = $urandom_range(15, 90);
    end
    g_phase_left--;
    r = $urandom_range(0, 99);
    if (g_hi >= g_cap || (r < 4 && g_prev_ok)) gen_emit(g_clear);
    else if (r < 30 || !g_prev_ok) gen_emit($urandom_range(0, g_clear - 1));
    else if (r < 42) gen_emit(g_hi);
    else if (g_hi > g_clear + 2) gen_emit($urandom_range(g_clear + 2, g_hi - 1));
    else gen_emit($urandom_range(0, g_clear - 1));
  endfunction

  // One beat on the input channel, with a random gap before it.
  task automatic drive_beat(input logic act, input logic [7:0] b);
    int gap, r;
    gap = 0;
    if (s_burst > 0) begin
      s_burst--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) s_burst = $urandom_range(20, 80);
      else if (r < 55) gap = 0;
      else if (r < 85) gap = $urandom_range(1, 3);
      else if (r < 97) gap = $urandom_range(4, 12);
      else gap = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.action    = act;
    in_ch.code_byte = b;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    @(negedge clk);
    in_ch.valid = 1'b0;
    sent++;
  endtask

  task automatic load_min_size(input logic [3:0] v);
    while (open_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Pushes the bytes a code needs, then pulls every byte of its expansion.
  task automatic play_code(input lzw_code_t e);
    logic [7:0] b;
    if (e.is_cfg) begin
      load_min_size(e.cfg);
      return;
    end
    if (have_bits < e.width && (force_odd || $urandom_range(0, 9) == 0))
      drive_beat(gld_pkg::ACT_PULL, 8'($urandom));
    while (have_bits < e.width) begin
      for (int k = 0; k < 8; k++) begin
        while (bitq.size() == 0) begin
          if (g_stop) bitq.push_back(1'b0);
          else gen_random();
        end
        b[k] = bitq.pop_front();
      end
      drive_beat(gld_pkg::ACT_PUSH, b);
      have_bits += 8;
    end
    // A complete code is waiting, so this push must be refused.
    if (force_odd || $urandom_range(0, 11) == 0)
      drive_beat(gld_pkg::ACT_PUSH, 8'($urandom));
    have_bits -= e.width;
    drive_beat(gld_pkg::ACT_PULL, 8'($urandom));
    for (int k = 1; k < e.len; k++) drive_beat(gld_pkg::ACT_PULL, 8'($urandom));
  endtask

  // Output side: random stalls, bursts of steady ready, and one long hold-off.
  initial begin
    int r;
    out_ch.ready = 1'b0;
    r_burst   = 0;
    hold_left = 0;
    held      = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else if (!held && sent >= 300) begin
        held         = 1;
        hold_left    = 400;
        out_ch.ready = 1'b0;
      end else if (r_burst > 0) begin
        out_ch.ready = 1'b1;
        r_burst--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          r_burst      = $urandom_range(20, 60);
          out_ch.ready = 1'b1;
        end else if (r < 70) begin
          out_ch.ready = 1'b1;
        end else if (r < 97) begin
          out_ch.ready = 1'b0;
        end else begin
          hold_left    = $urandom_range(10, 40);
          out_ch.ready = 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.action    = gld_pkg::ACT_PUSH;
    in_ch.code_byte = 8'd0;
    cfg_we          = 1'b0;
    cfg_data        = 4'd0;
    idle_cycles     = 0;
    sent            = 0;
    s_burst         = 0;
    have_bits       = 0;
    cfg_idx         = 0;
    g_stop          = 0;
    g_lit           = 8;
    gen_restart();
    g_cap        = 4096;
    g_phase_left = 0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed opening: empty pull, extreme literals, a repeat-previous code, clear.
    force_odd = 1;
    drive_beat(gld_pkg::ACT_PULL, 8'hFF);
    gen_emit(0);
    gen_emit(255);
    gen_emit(g_hi);
    gen_emit(g_clear + 2);
    gen_emit(g_clear);
    gen_emit(128);
    gen_emit(127);
    play_code(codeq.pop_front());
    force_odd = 0;

    while (sent < ITEM_TARGET) begin
      if (codeq.size() == 0) gen_random();
      play_code(codeq.pop_front());
    end

    // Finish the stream with either an end code or a code beyond the table.
    g_stop = 1;
    if ($urandom_range(0, 1) == 0) begin
      gen_emit(g_clear + 1);
    end else begin
      gen_emit(g_clear);
      gen_emit(g_clear + 2);
    end
    while (codeq.size() > 0) play_code(codeq.pop_front());
    repeat (8) drive_beat(1'($urandom_range(0, 1)), 8'($urandom));

    while (open_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// File: files.f
hdl/gld_pkg.sv
hdl/gld_ifs.sv
hdl/gif_lzw_decoder_core.sv
sim/gld_lzw_checker.sv
sim/tb_gif_lzw_decoder_core.sv
